/* design/gpe_pkg.sv */
`default_nettype none
package gpe_pkg;

  localparam int SLICE_BITS = 8;
  localparam int COLOR_W = 16;
  localparam int COL_W = 9;

  localparam logic [1:0] CFG_FG_COLOR = 2'd0;
  localparam logic [1:0] CFG_BG_COLOR = 2'd1;
  localparam logic [1:0] CFG_TRANSPARENT = 2'd2;

  localparam logic [15:0] CMD_ROW_ADDR = 16'h004F;
  localparam logic [15:0] CMD_COL_ADDR = 16'h004E;
  localparam logic [15:0] CMD_RAM_WRITE = 16'h0022;

  typedef struct packed {
    logic [7:0] x_start;
    logic [8:0] y_row;
    logic [SLICE_BITS-1:0] row_bits;
    logic continue_row;
  } in_item_t;

  typedef struct packed {
    logic is_data;
    logic [15:0] bus_word;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic transparent_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    B_START,
    B_ADDR,
    B_PIXEL
  } back_state_t;

  typedef enum logic [2:0] {
    AS_ROW_CMD,
    AS_ROW_DATA,
    AS_COL_CMD,
    AS_COL_DATA,
    AS_WRITE_CMD
  } addr_step_t;

endpackage
`default_nettype wire

/* design/gpe_front.sv */
`default_nettype none
module gpe_front
  import gpe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t request,
  output logic          head_valid,
  output in_item_t      head,
  input  wire logic     head_pop
);

  in_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* design/gpe_back.sv */
`default_nettype none
module gpe_back
  import gpe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     head_valid,
  input  wire in_item_t head,
  output logic          head_pop,
  input  wire logic     word_ready,
  output logic          word_valid,
  output out_item_t     word
);

  back_state_t state;
  back_state_t state_next;
  addr_step_t  step;
  addr_step_t  step_next;
  logic [2:0]  pix;
  logic [2:0]  pix_next;
  logic        readdr;
  logic        readdr_next;

  logic             addr_mode;
  addr_step_t       cur_step;
  logic [2:0]       cur_pix;
  logic             cur_readdr;
  logic             bit_set;
  logic [COL_W-1:0] col;
  logic             emit;

  assign emit = head_valid && word_ready;
  assign word_valid = head_valid;
  assign head_pop = emit && word.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_START;
      step <= AS_ROW_CMD;
      pix <= 3'd0;
      readdr <= 1'b0;
    end else if (emit) begin
      state <= state_next;
      step <= step_next;
      pix <= pix_next;
      readdr <= readdr_next;
    end
  end

  always_comb begin
    addr_mode = (state == B_START) ? !head.continue_row : (state == B_ADDR);
    cur_step = (state == B_START) ? AS_ROW_CMD : step;
    cur_pix = (state == B_START) ? 3'd0 : pix;
    cur_readdr = (state == B_ADDR) && readdr;
    bit_set = head.row_bits[3'd7 - cur_pix];
    col = cur_readdr ? ({1'b0, head.x_start} + {6'd0, cur_pix} + 9'd1)
                     : {1'b0, head.x_start};

    word = '0;
    state_next = state;
    step_next = cur_step;
    pix_next = cur_pix;
    readdr_next = cur_readdr;

    if (addr_mode) begin
      state_next = B_ADDR;
      case (cur_step)
        AS_ROW_CMD: begin
          word.bus_word = CMD_ROW_ADDR;
          step_next = AS_ROW_DATA;
        end
        AS_ROW_DATA: begin
          word.is_data = 1'b1;
          word.bus_word = {7'd0, head.y_row};
          step_next = AS_COL_CMD;
        end
        AS_COL_CMD: begin
          word.bus_word = CMD_COL_ADDR;
          step_next = AS_COL_DATA;
        end
        AS_COL_DATA: begin
          word.is_data = 1'b1;
          word.bus_word = {7'd0, col};
          step_next = AS_WRITE_CMD;
        end
        AS_WRITE_CMD: begin
          word.bus_word = CMD_RAM_WRITE;
          step_next = AS_ROW_CMD;
          readdr_next = 1'b0;
          if (!cur_readdr) begin
            state_next = B_PIXEL;
            pix_next = 3'd0;
          end else if (cur_pix == 3'd7) begin
            word.last = 1'b1;
            state_next = B_START;
          end else begin
            state_next = B_PIXEL;
            pix_next = cur_pix + 3'd1;
          end
        end
        default: begin
          step_next = AS_ROW_CMD;
        end
      endcase
    end else if (bit_set || !cfg.transparent_mode) begin
      word.is_data = 1'b1;
      word.bus_word = bit_set ? cfg.fg_color : cfg.bg_color;
      if (cur_pix == 3'd7) begin
        word.last = 1'b1;
        state_next = B_START;
      end else begin
        state_next = B_PIXEL;
        pix_next = cur_pix + 3'd1;
      end
    end else begin
      word.bus_word = CMD_ROW_ADDR;
      state_next = B_ADDR;
      step_next = AS_ROW_DATA;
      readdr_next = 1'b1;
    end
  end

endmodule
`default_nettype wire

/* design/gpe_out_queue.sv */
`default_nettype none
module gpe_out_queue
  import gpe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      word_valid,
  input  wire out_item_t word,
  output logic           word_ready,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      result
);

  out_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign word_ready = (count != 2'd2);
  assign empty = (count == 2'd0);
  assign result = slots[rd_ptr];
  assign do_push = word_valid && word_ready;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* design/glyph_row_pixel_expander_top.sv */
`default_nettype none
// A slice request produces 8 to 45 bus words, one per cycle while the result
// queue has room, and occupies the sequencer until its last word is emitted.
// Throughput is limited by the sequencer and by room in the result queue.
// Two-entry queues sit on the request side and on the result side.
// Synchronous reset empties both queues, restarts the sequencer and clears the
// color and mode registers to zero.
module glyph_row_pixel_expander_top
  import gpe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire in_item_t     request,
  output logic              empty,
  input  wire logic         pop,
  output out_item_t         result,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);

  cfg_t      cfg;
  logic      head_valid;
  in_item_t  head;
  logic      head_pop;
  logic      word_valid;
  logic      word_ready;
  out_item_t word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FG_COLOR: cfg.fg_color <= cfg_data;
        CFG_BG_COLOR: cfg.bg_color <= cfg_data;
        CFG_TRANSPARENT: cfg.transparent_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  gpe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .request    (request),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  gpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .word_ready (word_ready),
    .word_valid (word_valid),
    .word       (word)
  );

  gpe_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word       (word),
    .word_ready (word_ready),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gpe_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RECEIVER_HOLD = 300;
  localparam int DRAIN_PAUSE = 6;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t request = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [15:0] fg_color_q;
  logic [15:0] bg_color_q;
  logic transparent_q;

  out_item_t expected_words[$];
  out_item_t want_word;
  int error_count = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_cycles = 0;
  int stall_count = 0;

  glyph_row_pixel_expander_top dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .request(request),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic put_word(input logic is_data, input logic [15:0] word);
    out_item_t w;
    w.is_data = is_data;
    w.bus_word = word;
    w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  task automatic put_address(input logic [15:0] col, input logic [15:0] row);
    put_word(1'b0, CMD_ROW_ADDR);
    put_word(1'b1, row);
    put_word(1'b0, CMD_COL_ADDR);
    put_word(1'b1, col);
    put_word(1'b0, CMD_RAM_WRITE);
  endtask

  task automatic predict_bus_words(input in_item_t item);
    out_item_t tail;
    if (!item.continue_row) begin
      put_address({8'd0, item.x_start}, {7'd0, item.y_row});
    end
    for (int j = 0; j < SLICE_BITS; j++) begin
      if (item.row_bits[SLICE_BITS - 1 - j]) begin
        put_word(1'b1, fg_color_q);
      end else if (!transparent_q) begin
        put_word(1'b1, bg_color_q);
      end else begin
        put_address(16'(item.x_start) + 16'(j) + 16'd1, {7'd0, item.y_row});
      end
    end
    tail = expected_words[expected_words.size() - 1];
    tail.last = 1'b1;
    expected_words[expected_words.size() - 1] = tail;
  endtask

  task automatic send_slice(input in_item_t item);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    request = item;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_bus_words(item);
  endtask

  task automatic send_fields(input logic [7:0] x, input logic [8:0] y,
                             input logic [7:0] bits, input logic cont);
    in_item_t item;
    item.x_start = x;
    item.y_row = y;
    item.row_bits = bits;
    item.continue_row = cont;
    send_slice(item);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      CFG_FG_COLOR: fg_color_q = data;
      CFG_BG_COLOR: bg_color_q = data;
      CFG_TRANSPARENT: transparent_q = data[0];
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_fields(8'd17, 9'd33, 8'hC3, 1'b0);
    send_fields(8'd25, 9'd33, 8'h3C, 1'b1);
    wait_drained();
  endtask

  task automatic test_opaque_extremes();
    write_reg(CFG_FG_COLOR, 16'hFFFF);
    write_reg(CFG_BG_COLOR, 16'h0000);
    write_reg(CFG_TRANSPARENT, 16'h0000);
    send_fields(8'd0, 9'd0, 8'h00, 1'b0);
    send_fields(8'd255, 9'd511, 8'hFF, 1'b0);
    send_fields(8'd8, 9'd100, 8'hA5, 1'b1);
    send_fields(8'd128, 9'd256, 8'h80, 1'b0);
    send_fields(8'd136, 9'd256, 8'h01, 1'b1);
    wait_drained();
    write_reg(CFG_FG_COLOR, 16'h0000);
    write_reg(CFG_BG_COLOR, 16'hFFFF);
    send_fields(8'd200, 9'd311, 8'h5A, 1'b0);
    send_fields(8'd208, 9'd311, 8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_transparent_readdress();
    write_reg(CFG_FG_COLOR, 16'hF81F);
    write_reg(CFG_BG_COLOR, 16'h07E0);
    write_reg(CFG_TRANSPARENT, 16'hFFFF);
    // A clear row at the right edge re-addresses past column 255.
    send_fields(8'd255, 9'd511, 8'h00, 1'b0);
    send_fields(8'd248, 9'd7, 8'h00, 1'b1);
    send_fields(8'd0, 9'd0, 8'hFF, 1'b0);
    send_fields(8'd64, 9'd300, 8'h5A, 1'b0);
    send_fields(8'd72, 9'd300, 8'h81, 1'b1);
    send_fields(8'd250, 9'd1, 8'h7E, 1'b1);
    wait_drained();
  endtask

  task automatic test_unused_register();
    // Writes to the spare index must leave every color and mode unchanged.
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_fields(8'd40, 9'd200, 8'h96, 1'b0);
    wait_drained();
    write_reg(CFG_TRANSPARENT, 16'h0000);
    write_reg(CFG_UNUSED, 16'h0001);
    send_fields(8'd48, 9'd200, 8'h69, 1'b1);
    wait_drained();
  endtask

  function automatic logic [7:0] random_bits();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic randomize_config();
    write_reg(CFG_FG_COLOR, 16'($urandom));
    write_reg(CFG_BG_COLOR, 16'($urandom));
    write_reg(CFG_TRANSPARENT, 16'($urandom));
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    int sent;
    int run_len;
    logic [7:0] x;
    logic [8:0] y;
    sent = 0;
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    randomize_config();
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_fields(8'($urandom), 9'($urandom), random_bits(), 1'($urandom));
        sent++;
      end else begin
        // A glyph row: one addressed slice followed by up to three continuation slices.
        x = 8'($urandom);
        y = 9'($urandom);
        run_len = $urandom_range(1, 4);
        for (int k = 0; k < run_len; k++) begin
          send_fields(x, y, random_bits(), k != 0);
          x = x + 8'd8;
          sent++;
        end
      end
      if (sent % 25 < 4 && $urandom_range(0, 2) == 0) begin
        wait_drained();
        randomize_config();
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_reg(CFG_TRANSPARENT, 16'h0001);
    hold_cycles = RECEIVER_HOLD;
    for (int k = 0; k < 8; k++) begin
      send_fields(8'($urandom), 9'($urandom), random_bits(), 1'b0);
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      pop = 1'b0;
      hold_cycles--;
    end else begin
      pop = ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected bus word: is_data=%0b word=%h last=%0b",
                   result.is_data, result.bus_word, result.last);
        end
      end else begin
        want_word = expected_words.pop_front();
        if (result.is_data !== want_word.is_data || result.bus_word !== want_word.bus_word ||
            result.last !== want_word.last) begin
          error_count++;
          if (error_count <= 10) begin
            $display({"bus word mismatch: expected is_data=%0b word=%h last=%0b, ",
                      "got is_data=%0b word=%h last=%0b"},
                     want_word.is_data, want_word.bus_word, want_word.last,
                     result.is_data, result.bus_word, result.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("[glyph_row_pixel_expander_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    fg_color_q = '0;
    bg_color_q = '0;
    transparent_q = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_opaque_extremes();
    test_transparent_readdress();
    test_unused_register();
    test_random_traffic(32, 73, 40);
    test_backpressure();
    test_random_traffic(73, 32, 40);
    test_random_traffic(0, 0, 40);
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("[glyph_row_pixel_expander_top] OK");
    end else begin
      $display("[glyph_row_pixel_expander_top] ERROR");
    end
    $finish;
  end

endmodule
